@@ rtl/bale_pkg.sv @@
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants for the bounded array list engine
// Operation codes, status codes, controller states and the control bundle
// broadcast from the controller to every storage cell.
// ----------------------------------------------------------------------------
package bale_pkg;

    // Default geometry
    localparam int DEPTH_DEF      = 256;
    localparam int WORD_WIDTH_DEF = 32;

    // Count and index width large enough for the deepest supported list (4096)
    localparam int CNT_W = 13;

    // Field widths fixed by the interface
    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CAP_W    = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Cells per first-level group of the read reduction
    localparam int GROUP_SIZE = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_GET    = 3'd2,
        MODE_SET    = 3'd3,
        MODE_INSERT = 3'd4,
        MODE_REMOVE = 3'd5,
        MODE_CLEAR  = 3'd6
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_BOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REDUCE
    } t_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INSERT,
        CMD_REMOVE
    } t_cmd;

    // Broadcast to all cells for one operation
    typedef struct packed {
        t_cmd             cmd;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic             rd_en;
        logic [CNT_W-1:0] rd_idx;
    } t_cell_ctrl;

endpackage

@@ rtl/bale_cell.sv @@
// ----------------------------------------------------------------------------
// bale_cell: one storage cell of the list
// Holds one entry and, on command, loads the new word, takes the entry of its
// lower neighbor (insert) or of its upper neighbor (remove). Drives its entry
// onto the read tap when selected.
// ----------------------------------------------------------------------------
module bale_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  bale_pkg::t_cell_ctrl    i_ctrl,
    input  logic [WORD_WIDTH-1:0]   i_word,
    input  logic [WORD_WIDTH-1:0]   i_lower,
    input  logic [WORD_WIDTH-1:0]   i_upper,
    output logic [WORD_WIDTH-1:0]   o_word,
    output logic [WORD_WIDTH-1:0]   o_tap
);
    import bale_pkg::*;

    localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    // Pick load, shift from a neighbor, or hold
    always_comb begin
        n_word = r_word;
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                if (i_ctrl.idx == POS) n_word = i_word;
            end
            CMD_INSERT: begin
                if (i_ctrl.idx == POS) begin
                    n_word = i_word;
                end else if (POS > i_ctrl.idx && POS <= i_ctrl.count) begin
                    n_word = i_lower;
                end
            end
            CMD_REMOVE: begin
                if (POS >= i_ctrl.idx && POS_NEXT < i_ctrl.count) n_word = i_upper;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Entry storage, no reset: read only after written
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = (i_ctrl.rd_en && i_ctrl.rd_idx == POS) ? r_word : '0;

endmodule

@@ rtl/bounded_array_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core: fixed-capacity ordered list of words
// A command accepted in idle passes through the operation and read reduction
// states, and its result is registered onto o_done after the reduction state;
// busy is high in both states, so no new command is accepted until idle.
// Reset (synchronous, active low) empties the list and restores the capacity
// limit to 256; entry contents are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_core #(
    parameter int DEPTH      = bale_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = bale_pkg::WORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bale_pkg::MODE_W-1:0]    i_mode,
    input  logic [bale_pkg::POS_W-1:0]     i_position,
    input  logic [WORD_WIDTH-1:0]          i_item_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bale_pkg::CAP_W-1:0]     i_cfg_data,
    output logic                           o_done,
    output logic [WORD_WIDTH-1:0]          o_read_word,
    output logic [bale_pkg::STATUS_W-1:0]  o_status,
    output logic [bale_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                           o_is_empty
);
    import bale_pkg::*;

    localparam int NG = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CAP_W-1:0]   r_cap;
    logic               r_done;

    // Command and result payload
    logic [MODE_W-1:0]     r_mode;
    logic [POS_W-1:0]      r_pos;
    logic [WORD_WIDTH-1:0] r_item;
    t_status               r_stat, n_stat;
    logic                  r_rd_en;
    logic [WORD_WIDTH-1:0] r_read_word;
    t_status               r_out_stat;
    logic [CNT_W-1:0]      r_out_count;

    // Cell row and read reduction
    t_cell_ctrl            s_ctrl, n_ctrl;
    logic [WORD_WIDTH-1:0] w_word [DEPTH];
    logic [WORD_WIDTH-1:0] w_tap  [DEPTH];
    logic [WORD_WIDTH-1:0] r_grp  [NG];
    logic [WORD_WIDTH-1:0] n_grp  [NG];
    logic [WORD_WIDTH-1:0] s_rd_or;

    logic             s_accept;
    logic             s_exec;
    logic [CNT_W-1:0] s_limit;
    logic [CNT_W-1:0] s_pos;
    logic [CNT_W-1:0] s_clamp;
    logic             s_full;

    assign s_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_accept) n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_REDUCE;
            ST_REDUCE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy   = 1'b0;
        s_exec = 1'b0;
        case (r_state)
            ST_IDLE:   busy = 1'b0;
            ST_EXEC: begin
                busy   = 1'b1;
                s_exec = 1'b1;
            end
            ST_REDUCE: busy = 1'b1;
            default:   busy = 1'b0;
        endcase
    end

    // Decode the operation against the current count
    assign s_limit = ({4'd0, r_cap} > DEPTH_C) ? DEPTH_C : {4'd0, r_cap};
    assign s_full  = r_count >= s_limit;
    assign s_pos   = CNT_W'(r_pos);
    assign s_clamp = (s_pos > r_count) ? r_count : s_pos;

    always_comb begin
        n_ctrl  = '{cmd: CMD_NONE, idx: '0, count: r_count, rd_en: 1'b0, rd_idx: s_pos};
        n_stat  = STAT_OK;
        n_count = r_count;
        case (r_mode)
            MODE_PUSH: begin
                if (s_full) begin
                    n_stat = STAT_FULL;
                end else begin
                    n_ctrl.cmd = CMD_LOAD;
                    n_ctrl.idx = r_count;
                    n_count    = r_count + 1'b1;
                end
            end
            MODE_POP: begin
                if (r_count == '0) begin
                    n_stat = STAT_EMPTY;
                end else begin
                    n_ctrl.rd_en  = 1'b1;
                    n_ctrl.rd_idx = r_count - 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            MODE_GET: begin
                if (s_pos >= r_count) n_stat = STAT_BOUND;
                else                  n_ctrl.rd_en = 1'b1;
            end
            MODE_SET: begin
                if (s_pos >= r_count) begin
                    n_stat = STAT_BOUND;
                end else begin
                    n_ctrl.cmd = CMD_LOAD;
                    n_ctrl.idx = s_pos;
                end
            end
            MODE_INSERT: begin
                if (s_full) begin
                    n_stat = STAT_FULL;
                end else begin
                    n_ctrl.cmd = CMD_INSERT;
                    n_ctrl.idx = s_clamp;
                    n_count    = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (s_pos >= r_count) begin
                    n_stat = STAT_BOUND;
                end else begin
                    n_ctrl.cmd   = CMD_REMOVE;
                    n_ctrl.idx   = s_pos;
                    n_ctrl.rd_en = 1'b1;
                    n_count      = r_count - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_stat = STAT_OK;
            end
        endcase
    end

    // Drive the cell row only during the operation cycle
    always_comb begin
        s_ctrl = n_ctrl;
        if (!s_exec) begin
            s_ctrl.cmd   = CMD_NONE;
            s_ctrl.rd_en = 1'b0;
        end
    end

    // Row of cells, each linked to its neighbors; the end cells see zero past the row
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_WIDTH-1:0] w_lower;
            logic [WORD_WIDTH-1:0] w_upper;
            if (g == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_word[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_word[g+1];
            end
            bale_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .INDEX      (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (s_ctrl),
                .i_word  (r_item),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .o_word  (w_word[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    // First reduction level: OR the taps of each group
    always_comb begin
        for (int gi = 0; gi < NG; gi++) begin
            n_grp[gi] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (gi * GROUP_SIZE + k < DEPTH) begin
                    n_grp[gi] = n_grp[gi] | w_tap[gi * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // Second reduction level over the group registers
    always_comb begin
        s_rd_or = '0;
        for (int gi = 0; gi < NG; gi++) begin
            s_rd_or = s_rd_or | r_grp[gi];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_REDUCE);
            if (s_exec)                     r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) r_cap   <= i_cfg_data;
        end
    end

    // Capture the command beat, the operation outcome and the result beat
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode <= i_mode;
            r_pos  <= i_position;
            r_item <= i_item_word;
        end
        if (s_exec) begin
            r_stat  <= n_stat;
            r_rd_en <= n_ctrl.rd_en;
        end
        if (r_state == ST_REDUCE) begin
            r_read_word <= r_rd_en ? s_rd_or : '0;
            r_out_stat  <= r_stat;
            r_out_count <= r_count;
        end
    end

    assign o_done        = r_done;
    assign o_read_word   = r_read_word;
    assign o_status      = r_out_stat;
    assign o_entry_count = COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);

    // Checks
    a_done_after_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == ST_REDUCE)
        else $error("result beat without a reduction cycle");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_error_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != STAT_OK |-> o_read_word == '0)
        else $error("failed operation returned a word");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> busy ##1 busy)
        else $error("busy dropped before result");

    a_full_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_exec && n_stat == STAT_FULL |=> r_count == $past(r_count))
        else $error("full operation changed the count");

endmodule
